// ----- rtl/core/hfdn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hfdn_pkg
// Shared constants, widths and types of the Householder FDN reverb core.
// ============================================================================
package hfdn_pkg;

    localparam int MAX_LINES     = 8;
    localparam int ADDR_BITS     = 16;
    localparam int DELAY_WORDS   = 1 << ADDR_BITS;
    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 18;
    localparam int OFFSET_BITS   = 16;
    localparam int LEAK_BITS     = 16;
    localparam int LEAK_FRAC     = 15;
    localparam int COUNT_BITS    = 4;
    localparam int INDEX_BITS    = 3;

    localparam int LINE_IDX_BITS = $clog2(MAX_LINES);
    localparam int LINE_CNT_BITS = $clog2(MAX_LINES + 1);
    localparam int LINE_CAP      = MAX_LINES & ~3;

    // configuration register indexes
    localparam logic CFG_LINE_COUNT    = 1'b0;
    localparam logic CFG_FEEDBACK_LEAK = 1'b1;

    // input item kinds
    localparam logic OP_AUDIO = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef logic [ADDR_BITS-1:0]            addr_t;
    typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
    typedef logic signed [COEF_BITS-1:0]     coef_t;
    typedef logic [OFFSET_BITS-1:0]          offset_t;
    typedef logic [LINE_IDX_BITS-1:0]        idx_t;
    typedef logic [LINE_CNT_BITS-1:0]        cnt_t;

    typedef struct packed {
        logic                  we;
        addr_t                 addr;
        sample_t               wdata;
    } mem_req_t;

    typedef struct packed {
        logic                  load;
        logic                  state_we;
        idx_t                  idx;
        offset_t               end_offset;
        coef_t                 gain_in;
        coef_t                 gain_fb;
        sample_t               state;
    } line_wr_t;

    typedef struct packed {
        offset_t               end_offset;
        coef_t                 gain_in;
        coef_t                 gain_fb;
        sample_t               state;
    } line_rd_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]       line_count;
        logic signed [LEAK_BITS-1:0] feedback_leak;
    } cfg_t;

    typedef struct packed {
        logic                  op;
        sample_t               audio_in;
        logic [INDEX_BITS-1:0] line_index;
        offset_t               line_end_offset;
        coef_t                 line_gain_input;
        coef_t                 line_gain_feedback;
    } in_item_t;

    typedef struct packed {
        logic                  valid;
        sample_t               left_out;
        sample_t               right_out;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/hfdn_delay_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hfdn_delay_mem
// Single-port circular delay memory shared by all lines, registered read.
// ============================================================================
module hfdn_delay_mem (
    input  wire logic              clk,
    input  wire hfdn_pkg::mem_req_t req,
    output hfdn_pkg::sample_t      rdata
);
    import hfdn_pkg::*;

    sample_t mem [DELAY_WORDS];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/core/hfdn_line_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hfdn_line_regs
// Per-line end offsets, filter gains and one-pole filter state.
// ============================================================================
module hfdn_line_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hfdn_pkg::line_wr_t wr,
    input  wire hfdn_pkg::idx_t     rd_idx,
    output hfdn_pkg::line_rd_t      rd
);
    import hfdn_pkg::*;

    offset_t end_reg   [MAX_LINES];
    coef_t   gin_reg   [MAX_LINES];
    coef_t   gfb_reg   [MAX_LINES];
    sample_t state_reg [MAX_LINES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LINES; i++)
            begin
                end_reg[i]   <= '0;
                gin_reg[i]   <= '0;
                gfb_reg[i]   <= '0;
                state_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.load)
            begin
                end_reg[wr.idx] <= wr.end_offset;
                gin_reg[wr.idx] <= wr.gain_in;
                gfb_reg[wr.idx] <= wr.gain_fb;
            end
            if (wr.state_we)
            begin
                state_reg[wr.idx] <= wr.state;
            end
        end
    end

    always_comb
    begin
        rd.end_offset = end_reg[rd_idx];
        rd.gain_in    = gin_reg[rd_idx];
        rd.gain_fb    = gfb_reg[rd_idx];
        rd.state      = state_reg[rd_idx];
    end

endmodule
`default_nettype wire

// ----- rtl/core/hfdn_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// hfdn_engine
// Sequencer: clear sweep, line reads, output sums, leak, per-line filter and
// write-back through the shared delay memory.
// ============================================================================
module hfdn_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hfdn_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    input  wire hfdn_pkg::in_item_t in_item,
    output logic                    ready,
    input  wire logic               out_free,
    output hfdn_pkg::result_t       res,
    output hfdn_pkg::mem_req_t      mem_req,
    input  wire hfdn_pkg::sample_t  mem_rdata,
    output hfdn_pkg::line_wr_t      line_wr,
    output hfdn_pkg::idx_t          rd_idx,
    input  wire hfdn_pkg::line_rd_t line_rd
);
    import hfdn_pkg::*;

    localparam int SUM_BITS     = SAMPLE_BITS + LINE_IDX_BITS;
    localparam int PROD_BITS    = SUM_BITS + LEAK_BITS;
    localparam int TRICKLE_BITS = PROD_BITS - LEAK_FRAC;
    localparam int TX_BITS      = TRICKLE_BITS + 1;
    localparam int ACC_BITS     = TX_BITS + 1;
    localparam int P1_BITS      = ACC_BITS + COEF_BITS;
    localparam int P2_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int YSUM_BITS    = P1_BITS + 1;
    localparam int YQ_BITS      = YSUM_BITS - COEF_BITS + 1;

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_READ    = 7'b0000100,
        ST_LEAK    = 7'b0001000,
        ST_TRICKLE = 7'b0010000,
        ST_MUL     = 7'b0100000,
        ST_WRITE   = 7'b1000000
    } state_t;

    typedef logic signed [SUM_BITS-1:0] sum_t;

    state_t state_reg, state_next;
    addr_t  clr_cnt_reg, clr_cnt_next;
    addr_t  base_reg, base_next;
    cnt_t   n_reg, n_next;
    cnt_t   rd_j_reg, rd_j_next;
    logic   pend_reg, pend_next;
    idx_t   pend_idx_reg, pend_idx_next;
    idx_t   j_reg, j_next;

    sample_t x_reg, x_next;
    sum_t    sum_reg, sum_next;
    sum_t    left_reg, left_next;
    sum_t    right_reg, right_next;
    sample_t reads_reg [MAX_LINES];
    sample_t reads_next [MAX_LINES];
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic signed [TX_BITS-1:0]   tx_reg, tx_next;
    logic signed [P1_BITS-1:0]   p1_reg, p1_next;
    logic signed [P2_BITS-1:0]   p2_reg, p2_next;

    logic signed [PROD_BITS-1:0] prod_rnd;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [YSUM_BITS-1:0] ysum;
    sample_t                     y;
    cnt_t                        j_plus;
    idx_t                        nxt;
    cnt_t                        active_n;
    logic                        load_ok;
    int unsigned                 n_int;
    offset_t                     rd_off;

    function automatic sample_t sat_q(input logic signed [YQ_BITS-1:0] v);
        logic [YQ_BITS-SAMPLE_BITS:0] upper;
        upper = v[YQ_BITS-1:SAMPLE_BITS-1];
        if ((&upper) || !(|upper))
            return v[SAMPLE_BITS-1:0];
        else if (v[YQ_BITS-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    // line count: drop low two bits, clamp to four .. cap
    always_comb
    begin
        n_int = 32'(cfg.line_count) & 32'hC;
        if (n_int < 32'd4)
            n_int = 32'd4;
        if (n_int > 32'(LINE_CAP))
            n_int = 32'(LINE_CAP);
        active_n = cnt_t'(n_int);
    end

    assign load_ok  = 32'(in_item.line_index) < 32'(MAX_LINES);
    assign j_plus   = cnt_t'(j_reg) + cnt_t'(1);
    assign nxt      = (j_plus < n_reg) ? idx_t'(j_plus) : '0;
    assign prod_rnd = prod_reg + PROD_BITS'(1 << (LEAK_FRAC - 1));
    assign acc      = ACC_BITS'(reads_reg[nxt]) + ACC_BITS'(tx_reg);
    assign ysum     = YSUM_BITS'(p1_reg) + YSUM_BITS'(p2_reg)
                    + YSUM_BITS'(1 << (COEF_BITS - 2));
    assign y        = sat_q(ysum[YSUM_BITS-1:COEF_BITS-1]);
    assign rd_off   = (rd_j_reg == '0) ? '0 : line_rd.end_offset;
    assign ready    = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        base_next     = base_reg;
        n_next        = n_reg;
        rd_j_next     = rd_j_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        j_next        = j_reg;
        x_next        = x_reg;
        sum_next      = sum_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        reads_next    = reads_reg;
        prod_next     = prod_reg;
        tx_next       = tx_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        mem_req       = '0;
        line_wr       = '0;
        res           = '0;
        rd_idx        = j_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + addr_t'(1);
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.op == OP_LOAD)
                    begin
                        line_wr.load       = load_ok;
                        line_wr.idx        = idx_t'(in_item.line_index);
                        line_wr.end_offset = in_item.line_end_offset;
                        line_wr.gain_in    = in_item.line_gain_input;
                        line_wr.gain_fb    = in_item.line_gain_feedback;
                    end
                    else
                    begin
                        x_next     = in_item.audio_in;
                        n_next     = active_n;
                        rd_j_next  = '0;
                        pend_next  = 1'b0;
                        sum_next   = '0;
                        left_next  = '0;
                        right_next = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // line j reads at the end of line j-1, line 0 at the base
                rd_idx = idx_t'(rd_j_reg - cnt_t'(1));
                if (rd_j_reg < n_reg)
                begin
                    mem_req.addr  = base_reg + addr_t'(rd_off);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_t'(rd_j_reg);
                    rd_j_next     = rd_j_reg + cnt_t'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    reads_next[pend_idx_reg] = mem_rdata;
                    sum_next = sum_reg + sum_t'(mem_rdata);
                    if (pend_idx_reg[0])
                        left_next = left_reg - sum_t'(mem_rdata);
                    else
                        left_next = left_reg + sum_t'(mem_rdata);
                    if (pend_idx_reg[1])
                        right_next = right_reg - sum_t'(mem_rdata);
                    else
                        right_next = right_reg + sum_t'(mem_rdata);
                    if (rd_j_reg == n_reg)
                        state_next = ST_LEAK;
                end
            end
            ST_LEAK:
            begin
                prod_next = PROD_BITS'(sum_reg) * PROD_BITS'(cfg.feedback_leak);
                // hold until the output register can take the result
                if (out_free)
                begin
                    res.valid     = 1'b1;
                    res.left_out  = sat_q(YQ_BITS'(left_reg));
                    res.right_out = sat_q(YQ_BITS'(right_reg));
                    state_next    = ST_TRICKLE;
                end
            end
            ST_TRICKLE:
            begin
                tx_next    = TX_BITS'($signed(prod_rnd[PROD_BITS-1:LEAK_FRAC]))
                           + TX_BITS'(x_reg);
                j_next     = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                p1_next    = P1_BITS'($signed(line_rd.gain_in)) * P1_BITS'(acc);
                p2_next    = P2_BITS'($signed(line_rd.gain_fb))
                           * P2_BITS'($signed(line_rd.state));
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_req.we       = 1'b1;
                mem_req.addr     = base_reg + addr_t'(line_rd.end_offset);
                mem_req.wdata    = y;
                line_wr.state_we = 1'b1;
                line_wr.idx      = j_reg;
                line_wr.state    = y;
                if (j_plus == n_reg)
                begin
                    base_next  = base_reg + addr_t'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    j_next     = idx_t'(j_plus);
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            base_reg     <= '0;
            n_reg        <= '0;
            rd_j_reg     <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            j_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            base_reg     <= base_next;
            n_reg        <= n_next;
            rd_j_reg     <= rd_j_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            j_reg        <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        sum_reg   <= sum_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        reads_reg <= reads_next;
        prod_reg  <= prod_next;
        tx_reg    <= tx_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
    end

endmodule
`default_nettype wire

// ----- rtl/core/householder_fdn_reverb_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// householder_fdn_reverb_core
// Householder feedback delay network reverb, fixed point, stream ports.
// ============================================================================
// After reset the core sweeps the whole delay memory to zero, one word a
// cycle; s_tready stays low during the sweep while configuration writes
// are taken as usual. A line setup transfer (s_tuser = 1) is written to the
// line registers without leaving the idle state. An audio transfer for n
// active lines first has the single-port delay memory serve one read per
// line, then each line passes through the filter multipliers (ST_MUL) and
// writes its result back (ST_WRITE); s_tready stays low until the last
// write-back. The stereo result is held in an output register, so one
// result may wait on m_tready while the next sample is accepted.
module householder_fdn_reverb_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // audio_in [23:0], line_index [26:24], line_end_offset [42:27],
    // line_gain_input [60:43], line_gain_feedback [78:61], zero [79]
    input  wire logic [79:0] s_tdata,
    // op [0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // left_out [23:0], right_out [47:24]
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import hfdn_pkg::*;

    localparam int POS_INDEX = SAMPLE_BITS;
    localparam int POS_END   = POS_INDEX + INDEX_BITS;
    localparam int POS_GIN   = POS_END + OFFSET_BITS;
    localparam int POS_GFB   = POS_GIN + COEF_BITS;

    logic [COUNT_BITS-1:0]       line_count_reg;
    logic signed [LEAK_BITS-1:0] feedback_leak_reg;
    logic                        m_tvalid_reg;
    sample_t                     left_reg;
    sample_t                     right_reg;

    cfg_t      cfg;
    in_item_t  in_item;
    logic      in_valid;
    logic      ready;
    logic      out_free;
    result_t   res;
    mem_req_t  mem_req;
    sample_t   mem_rdata;
    line_wr_t  line_wr;
    idx_t      rd_idx;
    line_rd_t  line_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg    <= COUNT_BITS'(8);
            feedback_leak_reg <= -LEAK_BITS'(8192);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_COUNT:    line_count_reg    <= cfg_data[COUNT_BITS-1:0];
                CFG_FEEDBACK_LEAK: feedback_leak_reg <= cfg_data[LEAK_BITS-1:0];
                default:           line_count_reg    <= line_count_reg;
            endcase
        end
    end

    assign cfg.line_count    = line_count_reg;
    assign cfg.feedback_leak = feedback_leak_reg;

    always_comb
    begin
        in_item.op                 = s_tuser;
        in_item.audio_in           = s_tdata[POS_INDEX-1:0];
        in_item.line_index         = s_tdata[POS_END-1:POS_INDEX];
        in_item.line_end_offset    = s_tdata[POS_GIN-1:POS_END];
        in_item.line_gain_input    = s_tdata[POS_GFB-1:POS_GIN];
        in_item.line_gain_feedback = s_tdata[POS_GFB+COEF_BITS-1:POS_GFB];
    end

    assign s_tready = ready;
    assign in_valid = s_tvalid && ready;
    assign out_free = !m_tvalid_reg || m_tready;

    // output register: load a new result, drop the old one on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            left_reg  <= res.left_out;
            right_reg <= res.right_out;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {right_reg, left_reg};

    hfdn_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .ready     (ready),
        .out_free  (out_free),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .line_wr   (line_wr),
        .rd_idx    (rd_idx),
        .line_rd   (line_rd)
    );

    hfdn_delay_mem u_delay_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    hfdn_line_regs u_line_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (line_wr),
        .rd_idx (rd_idx),
        .rd     (line_rd)
    );

endmodule
`default_nettype wire
